>>> hw/rtl/pic_pkg.sv
`timescale 1ns / 1ps

package pic_pkg;

  typedef enum logic [2:0] {
    OP_REQUEST    = 3'd0,
    OP_RD_CTRL    = 3'd1,
    OP_RD_INDEX   = 3'd2,
    OP_RD_PRIO    = 3'd3,
    OP_RDCLR_PRIO = 3'd4,
    OP_WR_CTRL    = 3'd5,
    OP_WR_PRIO    = 3'd6,
    OP_CHECK      = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RDWAIT,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    op_t  op;
    logic scan_start;
    logic scan_done;
    logic out_free;
  } ctrl_status_t;

  typedef struct packed {
    logic busy;
    logic exec;
    logic rd_wait;
    logic scan;
    logic finish;
  } ctrl_cmd_t;

  localparam int unsigned LEVEL_BITS  = 4;
  localparam int unsigned DISABLE_BIT = 6;
  localparam int unsigned MAX_SCAN    = 31;
  localparam logic [4:0]  NONE_FOUND  = 5'd31;

endpackage

>>> hw/rtl/pic_ram.sv
`timescale 1ns / 1ps

module pic_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/pic_ctrl.sv
`timescale 1ns / 1ps

module pic_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  pic_pkg::ctrl_status_t status,
  output pic_pkg::ctrl_cmd_t    cmd
);

  pic_pkg::state_t state;
  pic_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pic_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      pic_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = pic_pkg::ST_EXEC;
        end
      end
      pic_pkg::ST_EXEC: begin
        if (status.op == pic_pkg::OP_RD_CTRL || status.op == pic_pkg::OP_WR_CTRL) begin
          state_next = pic_pkg::ST_RDWAIT;
        end else if (status.op == pic_pkg::OP_CHECK && status.scan_start) begin
          state_next = pic_pkg::ST_SCAN;
        end else begin
          state_next = pic_pkg::ST_FINISH;
        end
      end
      pic_pkg::ST_RDWAIT: begin
        state_next = pic_pkg::ST_FINISH;
      end
      pic_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_next = pic_pkg::ST_FINISH;
        end
      end
      pic_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_next = pic_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pic_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      pic_pkg::ST_IDLE: begin
        cmd.busy = 1'b0;
      end
      pic_pkg::ST_EXEC: begin
        cmd.busy = 1'b1;
        cmd.exec = 1'b1;
      end
      pic_pkg::ST_RDWAIT: begin
        cmd.busy    = 1'b1;
        cmd.rd_wait = 1'b1;
      end
      pic_pkg::ST_SCAN: begin
        cmd.busy = 1'b1;
        cmd.scan = 1'b1;
      end
      pic_pkg::ST_FINISH: begin
        cmd.busy   = 1'b1;
        cmd.finish = 1'b1;
      end
      default: begin
        cmd.busy = 1'b1;
      end
    endcase
  end

endmodule

>>> hw/rtl/priority_interrupt_controller.sv
`timescale 1ns / 1ps
// Register items go from the accepted transaction through EXEC and FINISH to the result;
// control word accesses add a RAM read (RDWAIT), and a check tick can add a line scan
// over at most MIN(NUM_LINES,31) lines that reads one control word a cycle.
// One transaction at a time: a new one is taken once the previous result is registered.
// Reset clears the line, threshold and scan state and out_valid; control words read as zero.
module priority_interrupt_controller #(
  parameter int unsigned NUM_LINES = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  req_type,
  input  logic [4:0]  line_index,
  input  logic [31:0] write_mask,
  input  logic [31:0] write_value,
  input  logic        cpu_irq_masked,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_raise,
  output logic [4:0]  taken_line
);

  localparam int unsigned IDXW       = $clog2(NUM_LINES);
  localparam int unsigned SCAN_LINES =
      (NUM_LINES < pic_pkg::MAX_SCAN) ? NUM_LINES : pic_pkg::MAX_SCAN;
  localparam logic [IDXW-1:0] SCAN_LAST = IDXW'(SCAN_LINES - 1);

  pic_pkg::ctrl_status_t status;
  pic_pkg::ctrl_cmd_t    cmd;
  logic                  accept;

  pic_pkg::op_t op_q;
  logic [4:0]   line_q;
  logic         in_range_q;
  logic [31:0]  wmask_q;
  logic [31:0]  wval_q;
  logic         cpu_masked_q;

  logic [NUM_LINES-1:0] pending;
  logic [NUM_LINES-1:0] enabled;
  logic [NUM_LINES-1:0] word_valid;
  logic [pic_pkg::LEVEL_BITS-1:0] thr;
  logic [4:0]           last_line;
  logic                 armed;

  logic [NUM_LINES-1:0] live;
  logic [IDXW-1:0]      ram_raddr;
  logic [31:0]          ram_rdata;
  logic                 ram_we;
  logic [31:0]          ram_wdata;
  logic                 rd_valid;
  logic [31:0]          cur_word;
  logic [31:0]          new_word;
  logic [IDXW-1:0]      line_addr;

  logic [IDXW-1:0] scan_idx;
  logic [IDXW-1:0] scan_idx_d;
  logic            scan_eval;
  logic            scan_hit;

  logic [31:0] res_data;
  logic        res_irq;
  logic        out_free;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = cmd.busy;
  assign out_free  = !out_valid || !out_stall;
  assign line_addr = line_q[IDXW-1:0];
  assign live      = pending & enabled;
  assign ram_raddr = cmd.scan ? scan_idx : line_addr;
  assign cur_word  = rd_valid ? ram_rdata : 32'd0;
  assign new_word  = (cur_word & ~wmask_q) | (wval_q & wmask_q);
  assign ram_we    = cmd.rd_wait && (op_q == pic_pkg::OP_WR_CTRL) && in_range_q;
  assign ram_wdata = new_word;
  assign scan_hit  = scan_eval && live[scan_idx_d] &&
                     (cur_word[pic_pkg::LEVEL_BITS-1:0] < thr);

  assign status.op         = op_q;
  assign status.scan_start = armed && !cpu_masked_q && (live != '0) && (thr != '0);
  assign status.scan_done  = scan_eval && (scan_hit || scan_idx_d == SCAN_LAST);
  assign status.out_free   = out_free;

  pic_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .status (status),
    .cmd    (cmd)
  );

  pic_ram #(
    .WIDTH (32),
    .DEPTH (NUM_LINES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_addr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // capture the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q         <= pic_pkg::op_t'(req_type);
      line_q       <= line_index;
      in_range_q   <= {1'b0, line_index} < 6'(NUM_LINES);
      wmask_q      <= write_mask;
      wval_q       <= write_value;
      cpu_masked_q <= cpu_irq_masked;
    end
    rd_valid <= word_valid[ram_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending    <= '0;
      enabled    <= '0;
      word_valid <= '0;
      thr        <= '0;
      last_line  <= '0;
      armed      <= 1'b0;
      scan_eval  <= 1'b0;
      scan_idx   <= '0;
    end else begin
      if (cmd.exec) begin
        scan_idx  <= '0;
        scan_eval <= 1'b0;
        case (op_q)
          pic_pkg::OP_REQUEST: begin
            if (in_range_q) begin
              pending <= pending | (NUM_LINES'(1) << line_q);
              armed   <= 1'b1;
            end
          end
          pic_pkg::OP_RDCLR_PRIO: begin
            thr <= '0;
          end
          pic_pkg::OP_WR_PRIO: begin
            thr <= (thr & ~wmask_q[pic_pkg::LEVEL_BITS-1:0]) |
                   (wval_q[pic_pkg::LEVEL_BITS-1:0] & wmask_q[pic_pkg::LEVEL_BITS-1:0]);
            pending <= pending & ~(NUM_LINES'(1) << last_line);
            armed   <= 1'b1;
          end
          pic_pkg::OP_CHECK: begin
            armed <= 1'b0;
          end
          default: begin
            armed <= armed;
          end
        endcase
      end
      if (ram_we) begin
        word_valid[line_addr] <= 1'b1;
        enabled[line_addr]    <= !new_word[pic_pkg::DISABLE_BIT];
        armed                 <= 1'b1;
      end
      if (cmd.scan) begin
        scan_eval  <= 1'b1;
        scan_idx_d <= scan_idx;
        if (scan_idx != SCAN_LAST) begin
          scan_idx <= scan_idx + 1'b1;
        end
        if (scan_hit) begin
          last_line <= 5'(scan_idx_d);
        end else if (status.scan_done) begin
          last_line <= pic_pkg::NONE_FOUND;
        end
      end
    end
  end

  // build the result
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_irq <= 1'b0;
      case (op_q)
        pic_pkg::OP_RD_INDEX: begin
          res_data <= {27'd0, last_line};
        end
        pic_pkg::OP_RD_PRIO, pic_pkg::OP_RDCLR_PRIO: begin
          res_data <= {28'd0, thr};
        end
        default: begin
          res_data <= 32'd0;
        end
      endcase
    end
    if (cmd.rd_wait && op_q == pic_pkg::OP_RD_CTRL && in_range_q) begin
      res_data <= cur_word;
    end
    if (cmd.scan && scan_hit) begin
      res_irq <= 1'b1;
    end
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && out_free) begin
      read_data  <= res_data;
      irq_raise  <= res_irq;
      taken_line <= last_line;
    end
  end

endmodule
